/* rtl/core/bqn_pkg.sv */
// ============================================================================
// bqn_pkg: shared types and constants for the biquad notch filter
// Coefficient format, config register indexes, sequencer states and the
// control word of the serial multiply-accumulate unit.
// ============================================================================
package bqn_pkg;

    // Coefficients are signed Q2.14
    localparam int COEF_WIDTH      = 16;
    localparam int COEF_FRAC       = 14;
    localparam int CFG_INDEX_WIDTH = 2;

    // Config register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FF_MID    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FB_FIRST  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FB_SECOND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_FB_END,
        ST_FF,
        ST_FF_END
    } state_t;

    // Control word for the serial MAC
    typedef struct packed {
        logic load;   // preset accumulator with the rounding offset
        logic step;   // add one partial term and shift right one bit
    } mac_ctrl_t;

endpackage

/* rtl/core/bqn_serial_mac.sv */
// ============================================================================
// bqn_serial_mac: bit-serial shift-right accumulator
// Adds one narrow partial term per cycle while step is set to the upper word and
// shifts the dropped bit into a low shift register; the result is the rounded sum.
// ============================================================================
module bqn_serial_mac #(
    parameter int HI_W = 18,
    parameter int LO_W = 24
) (
    input  logic                                       clk,
    input  bqn_pkg::mac_ctrl_t                         ctrl,
    input  logic signed [HI_W:0]                       term,
    output logic signed [HI_W+LO_W-bqn_pkg::COEF_FRAC-1:0] result
);
    import bqn_pkg::*;

    // half an LSB of the final result, for round half up
    localparam logic signed [HI_W-1:0] ROUND_INIT = HI_W'(1 << (COEF_FRAC - 1));

    logic signed [HI_W-1:0] hi_reg, hi_next;
    logic        [LO_W-1:0] lo_reg, lo_next;
    logic signed [HI_W:0]   sum;

    always_comb
    begin
        sum     = {hi_reg[HI_W-1], hi_reg} + term;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctrl.load)
        begin
            hi_next = ROUND_INIT;
        end
        else if (ctrl.step)
        begin
            hi_next = sum[HI_W:1];
            lo_next = {sum[0], lo_reg[LO_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    // full sum is {hi, lo}; drop the fraction bits (rounding already added)
    assign result = {hi_reg, lo_reg[LO_W-1:COEF_FRAC]};

endmodule

/* rtl/core/biquad_notch_filter.sv */
// ============================================================================
// biquad_notch_filter: second-order IIR notch section, direct form II
// The bit-serial MAC walks every bit of the delay words once for feedback
//   (ST_FB), loads w (ST_FB_END), walks them once for feedforward (ST_FF) and
//   commits in ST_FF_END, waiting on a stalled output; in_stall until ST_IDLE.
// Reset (rst_n low, async): delay line cleared, gain 1.0, other coefs zero,
//   output empty, ready for a sample as soon as reset is released.
// ============================================================================
module biquad_notch_filter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    // sample output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    // config write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bqn_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bqn_pkg::COEF_WIDTH-1:0]        cfg_data
);
    import bqn_pkg::*;

    // Accumulator upper word: must hold three coef-by-bit terms or a sample
    localparam int MAX_W = (COEF_WIDTH > SAMPLE_WIDTH) ? COEF_WIDTH : SAMPLE_WIDTH;
    localparam int HI_W  = MAX_W + 2;
    localparam int RES_W = HI_W + STATE_WIDTH - COEF_FRAC;
    localparam int CNT_W = $clog2(STATE_WIDTH);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_WIDTH - 1);
    // x enters at weight 2^14, i.e. on bit step COEF_FRAC
    localparam logic [CNT_W-1:0] CNT_XIN  = CNT_W'(COEF_FRAC);

    localparam logic signed [STATE_WIDTH-1:0]  W_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0]  W_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic signed [COEF_WIDTH-1:0] GAIN_RESET = COEF_WIDTH'(16384);

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [COEF_WIDTH-1:0] gain_reg, ff_mid_reg, fb_first_reg, fb_second_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic signed [STATE_WIDTH-1:0]  w_reg, w_next;      // new w, rotated during FF
    logic signed [STATE_WIDTH-1:0]  w1_reg, w1_next;    // delay_one, rotates each pass
    logic signed [STATE_WIDTH-1:0]  w2_reg, w2_next;    // delay_two, rotates each pass

    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg, sample_out_next;

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    logic      accept;
    logic      out_free;
    logic      last_bit;
    logic      rot_fb;
    logic      rot_ff;
    logic      load_w;
    logic      commit;
    mac_ctrl_t mac_ctrl;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign last_bit = (cnt_reg == CNT_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_FB;
            ST_FB:     if (last_bit) state_next = ST_FB_END;
            ST_FB_END: state_next = ST_FF;
            ST_FF:     if (last_bit) state_next = ST_FF_END;
            ST_FF_END: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall      = 1'b1;
        rot_fb        = 1'b0;
        rot_ff        = 1'b0;
        load_w        = 1'b0;
        commit        = 1'b0;
        mac_ctrl.load = 1'b0;
        mac_ctrl.step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                mac_ctrl.load = in_valid;
            end
            ST_FB:
            begin
                rot_fb        = 1'b1;
                mac_ctrl.step = 1'b1;
            end
            ST_FB_END:
            begin
                load_w        = 1'b1;
                mac_ctrl.load = 1'b1;
            end
            ST_FF:
            begin
                rot_ff        = 1'b1;
                mac_ctrl.step = 1'b1;
            end
            ST_FF_END:
            begin
                commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Partial term: coefficient times the current bit of each delay word.
    // The MSB of a two's complement word weighs -2^(N-1), so the sign of the
    // coefficient part flips on the last bit step.
    // ------------------------------------------------------------------------
    logic signed [HI_W:0] gain_ext, ff_mid_ext, fb_first_ext, fb_second_ext, x_ext;
    logic signed [HI_W:0] coef_sum;
    logic signed [HI_W:0] term;

    assign gain_ext      = {{(HI_W+1-COEF_WIDTH){gain_reg[COEF_WIDTH-1]}}, gain_reg};
    assign ff_mid_ext    = {{(HI_W+1-COEF_WIDTH){ff_mid_reg[COEF_WIDTH-1]}}, ff_mid_reg};
    assign fb_first_ext  = {{(HI_W+1-COEF_WIDTH){fb_first_reg[COEF_WIDTH-1]}}, fb_first_reg};
    assign fb_second_ext = {{(HI_W+1-COEF_WIDTH){fb_second_reg[COEF_WIDTH-1]}},
                            fb_second_reg};
    assign x_ext         = {{(HI_W+1-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};

    always_comb
    begin
        coef_sum = '0;
        term     = '0;
        if (rot_fb)
        begin
            // w = x*2^14 - b1*w1 - b2*w2
            coef_sum = (w1_reg[0] ? fb_first_ext  : '0)
                     + (w2_reg[0] ? fb_second_ext : '0);
            term     = (last_bit ? coef_sum : -coef_sum)
                     + ((cnt_reg == CNT_XIN) ? x_ext : '0);
        end
        else if (rot_ff)
        begin
            // y = k*w + m*w1 + k*w2
            coef_sum = (w_reg[0]  ? gain_ext   : '0)
                     + (w1_reg[0] ? ff_mid_ext : '0)
                     + (w2_reg[0] ? gain_ext   : '0);
            term     = last_bit ? -coef_sum : coef_sum;
        end
    end

    logic signed [RES_W-1:0] mac_result;

    bqn_serial_mac #(
        .HI_W (HI_W),
        .LO_W (STATE_WIDTH)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .term   (term),
        .result (mac_result)
    );

    // ------------------------------------------------------------------------
    // Saturation of the rounded sum: overflow when the bits from the top down to
    // the target sign position disagree.
    // ------------------------------------------------------------------------
    logic                           w_ovf, y_ovf;
    logic signed [STATE_WIDTH-1:0]  w_sat;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    always_comb
    begin
        w_ovf = !((&mac_result[RES_W-1:STATE_WIDTH-1]) ||
                  !(|mac_result[RES_W-1:STATE_WIDTH-1]));
        y_ovf = !((&mac_result[RES_W-1:SAMPLE_WIDTH-1]) ||
                  !(|mac_result[RES_W-1:SAMPLE_WIDTH-1]));
        if (w_ovf)
            w_sat = mac_result[RES_W-1] ? W_MIN : W_MAX;
        else
            w_sat = mac_result[STATE_WIDTH-1:0];
        if (y_ovf)
            y_sat = mac_result[RES_W-1] ? Y_MIN : Y_MAX;
        else
            y_sat = mac_result[SAMPLE_WIDTH-1:0];
    end

    // ------------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        cnt_next        = cnt_reg;
        x_next          = x_reg;
        w_next          = w_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        sample_out_next = sample_out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (mac_ctrl.load)
            cnt_next = '0;
        else if (mac_ctrl.step)
            cnt_next = cnt_reg + CNT_W'(1);

        if (accept)
            x_next = sample_in;

        // rotate right: after a full pass each word is back in place
        if (rot_fb || rot_ff)
        begin
            w1_next = {w1_reg[0], w1_reg[STATE_WIDTH-1:1]};
            w2_next = {w2_reg[0], w2_reg[STATE_WIDTH-1:1]};
        end
        if (rot_ff)
            w_next = {w_reg[0], w_reg[STATE_WIDTH-1:1]};
        if (load_w)
            w_next = w_sat;

        if (commit)
        begin
            w2_next         = w1_reg;
            w1_next         = w_reg;
            sample_out_next = y_sat;
            out_valid_next  = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            w1_reg        <= '0;
            w2_reg        <= '0;
            gain_reg      <= GAIN_RESET;
            ff_mid_reg    <= '0;
            fb_first_reg  <= '0;
            fb_second_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            w1_reg        <= w1_next;
            w2_reg        <= w2_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GAIN:      gain_reg      <= cfg_data;
                    CFG_FF_MID:    ff_mid_reg    <= cfg_data;
                    CFG_FB_FIRST:  fb_first_reg  <= cfg_data;
                    CFG_FB_SECOND: fb_second_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        w_reg          <= w_next;
        sample_out_reg <= sample_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign cfg_ready  = 1'b1;   // registers take a write every cycle

endmodule

/* rtl/core/bqn_checker.sv */
// ============================================================================
// bqn_checker: port-level checks for the biquad notch filter
// Watches the sample channels and config port of the top level.
// ============================================================================
module bqn_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    input logic                                cfg_valid,
    input logic                                cfg_ready
);

    logic in_beat;
    assign in_beat = in_valid && !in_stall;

    // one sample in flight: input closes right after a beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
    else $error("input not stalled after accepting a beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
    else $error("stalled result changed or dropped");

    // a new result only shows up at the end of a busy sequence
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy period");

    // a result cannot follow its input beat on the next cycle
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !$rose(out_valid))
    else $error("result appeared one cycle after input beat");

    // config writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind biquad_notch_filter bqn_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
